/* hw/rtl/sixf_pkg.sv */
// ----------------------------------------------------------------------------
// sixf_pkg: shared types and constants of the sync/id/length/XOR framer
// Holds the register indexes, the layout of one output run and its slots.
// ----------------------------------------------------------------------------
package sixf_pkg;

  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W = 2;
  localparam int RUN_BYTES = 6;
  localparam int SLOT_W  = $clog2(RUN_BYTES);

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [SLOT_W-1:0]    slot_t;

  localparam cfg_idx_t REG_SYNC_FIRST     = 2'd0;
  localparam cfg_idx_t REG_SYNC_SECOND    = 2'd1;
  localparam cfg_idx_t REG_PAYLOAD_LENGTH = 2'd2;

  localparam byte_t RST_SYNC_FIRST     = 8'd170;
  localparam byte_t RST_SYNC_SECOND    = 8'd85;
  localparam byte_t RST_PAYLOAD_LENGTH = 8'd16;

  // Slots of a run: sync, sync, frame id, length, payload byte, checksum.
  localparam slot_t SLOT_SYNC_FIRST = 3'd0;
  localparam slot_t SLOT_DATA       = 3'd4;
  localparam slot_t SLOT_CHECK      = 3'd5;

  typedef struct packed {
    logic [RUN_BYTES-1:0][BYTE_W-1:0] bytes;
    slot_t                            first;
    slot_t                            last;
  } run_t;

endpackage

/* hw/rtl/sync_id_length_xor_framer.sv */
// ----------------------------------------------------------------------------
// sync_id_length_xor_framer: byte framer with sync header and XOR checksum
// Wraps payload bytes into frames of sync, id, length, payload and checksum.
// ----------------------------------------------------------------------------
// Payload bytes enter on the in_ channel and framed bytes leave on the out_
// channel, one byte per request; both channels use valid and stall.
// The first byte of a frame produces five output requests (two sync bytes,
// frame id, length, payload byte), a middle byte one, and the last byte one
// more for the checksum, which carries out_end_of_frame. out_last_of_run
// marks the final output request caused by each input request.
// An accepted byte is expanded into a run and registered into the output
// run register, or into the second run register while the output one is busy.
// Throughput is set by the output port, one byte per cycle while out_stall
// is low; a frame of N payload bytes gives N + 5 output bytes. A second
// run register holds the next run, so input is taken while output stalls
// until both registers are full. Sync registers are sampled when a frame
// header is built, the length register for every byte. Reset loads the
// register defaults, frame id zero, and empties both run registers.
// ----------------------------------------------------------------------------
module sync_id_length_xor_framer #(
  parameter int MAX_PAYLOAD = 250
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [sixf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sixf_pkg::BYTE_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sixf_pkg::BYTE_W-1:0]  in_payload_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sixf_pkg::BYTE_W-1:0]  out_frame_byte,
  output logic                         out_end_of_frame,
  output logic                         out_last_of_run
);

  sixf_pkg::byte_t sync_first_r;
  sixf_pkg::byte_t sync_second_r;
  sixf_pkg::byte_t payload_length_r;

  sixf_pkg::byte_t frame_r, frame_nxt;
  sixf_pkg::byte_t pos_r, pos_nxt;
  sixf_pkg::byte_t xor_r, xor_nxt;

  sixf_pkg::run_t  emit_r, hold_r, run_new;
  logic            emit_valid_r, hold_valid_r;
  sixf_pkg::slot_t idx_r;

  sixf_pkg::byte_t len;
  sixf_pkg::byte_t xor_base;
  sixf_pkg::byte_t xor_new;
  sixf_pkg::byte_t pos_inc;
  logic            hdr;
  logic            eof;
  logic            in_fire;
  logic            out_fire;
  logic            run_done;
  logic            emit_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r     <= sixf_pkg::RST_SYNC_FIRST;
      sync_second_r    <= sixf_pkg::RST_SYNC_SECOND;
      payload_length_r <= sixf_pkg::RST_PAYLOAD_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        sixf_pkg::REG_SYNC_FIRST:     sync_first_r     <= cfg_wdata;
        sixf_pkg::REG_SYNC_SECOND:    sync_second_r    <= cfg_wdata;
        sixf_pkg::REG_PAYLOAD_LENGTH: payload_length_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (payload_length_r == '0) begin
      len = 8'd1;
    end else if (payload_length_r > sixf_pkg::BYTE_W'(MAX_PAYLOAD)) begin
      len = sixf_pkg::BYTE_W'(MAX_PAYLOAD);
    end else begin
      len = payload_length_r;
    end
  end

  assign hdr      = (pos_r == '0);
  assign xor_base = hdr ? len : xor_r;
  assign xor_new  = xor_base ^ in_payload_byte;
  assign pos_inc  = pos_r + 8'd1;
  assign eof      = (pos_inc >= len);

  always_comb begin
    run_new.bytes = {xor_new, in_payload_byte, len, frame_r, sync_second_r, sync_first_r};
    run_new.first = hdr ? sixf_pkg::SLOT_SYNC_FIRST : sixf_pkg::SLOT_DATA;
    run_new.last  = eof ? sixf_pkg::SLOT_CHECK : sixf_pkg::SLOT_DATA;
  end

  assign in_stall  = hold_valid_r;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = emit_valid_r;
  assign out_fire  = emit_valid_r && !out_stall;
  assign run_done  = out_fire && (idx_r == emit_r.last);
  assign emit_free = !emit_valid_r || run_done;

  assign out_frame_byte   = emit_r.bytes[idx_r];
  assign out_end_of_frame = (idx_r == sixf_pkg::SLOT_CHECK);
  assign out_last_of_run  = (idx_r == emit_r.last);

  always_comb begin
    frame_nxt = frame_r;
    pos_nxt   = pos_r;
    xor_nxt   = xor_r;
    if (in_fire) begin
      if (eof) begin
        frame_nxt = frame_r + 8'd1;
        pos_nxt   = '0;
        xor_nxt   = '0;
      end else begin
        pos_nxt = pos_inc;
        xor_nxt = xor_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
      pos_r   <= '0;
      xor_r   <= '0;
    end else begin
      frame_r <= frame_nxt;
      pos_r   <= pos_nxt;
      xor_r   <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_valid_r <= 1'b0;
      hold_valid_r <= 1'b0;
      idx_r        <= sixf_pkg::SLOT_SYNC_FIRST;
    end else if (emit_free) begin
      if (hold_valid_r) begin
        emit_valid_r <= 1'b1;
        hold_valid_r <= 1'b0;
        idx_r        <= hold_r.first;
      end else if (in_fire) begin
        emit_valid_r <= 1'b1;
        idx_r        <= run_new.first;
      end else begin
        emit_valid_r <= 1'b0;
      end
    end else begin
      if (out_fire) begin
        idx_r <= idx_r + 3'd1;
      end
      if (in_fire) begin
        hold_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_free) begin
      if (hold_valid_r) begin
        emit_r <= hold_r;
      end else if (in_fire) begin
        emit_r <= run_new;
      end
    end else if (in_fire) begin
      hold_r <= run_new;
    end
  end

  a_hold_needs_emit: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r |-> emit_valid_r)
    else $error("Queued run present while the output register is empty.");

  a_eof_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_frame) |-> out_last_of_run)
    else $error("Checksum byte is not the last byte of its run.");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> emit_valid_r)
    else $error("Accepted request did not produce a pending run.");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    emit_valid_r |-> (idx_r <= emit_r.last))
    else $error("Output slot ran past the end of its run.");

endmodule
